// ===== rtl/jpr_pkg.sv =====
// ----------------------------------------------------------------------------
// jpr_pkg
// Shared constants and types for the joystick packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package jpr_pkg;

  localparam int FRAME_BYTES  = 10;
  localparam int STORE_DEPTH  = FRAME_BYTES - 1;
  localparam int HELD_COUNT   = 8;
  localparam int POS_W        = 4;
  localparam int STALE_W      = 17;

  localparam logic [STALE_W-1:0] STALE_MAX     = {STALE_W{1'b1}};
  localparam logic [15:0]        TIMEOUT_RESET = 16'd1000;

  // frame event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_START_MARKER    = 2'd0;
  localparam logic [1:0] REG_CHECKSUM_ENABLE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd2;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic        checksum_enable;
    logic [7:0]  start_marker;
  } cfg_t;

  typedef struct packed {
    logic                       link_timeout;
    logic [1:0]                 frame_event;
    logic [HELD_COUNT-1:0][7:0] held;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/jpr_core.sv =====
// ----------------------------------------------------------------------------
// jpr_core
// Frame assembly, checksum test, held fields and link watchdog state.
// ----------------------------------------------------------------------------
`default_nettype none

module jpr_core
  import jpr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic             command,
  input  wire logic [7:0]       rx_byte,
  input  wire cfg_t             cfg,
  output result_t               res,
  output logic [POS_W-1:0]      position
);

  logic [POS_W-1:0]           pos, pos_next;
  logic [7:0]                 sum, sum_next;
  logic [STALE_W-1:0]         stale, stale_next;
  logic [HELD_COUNT-1:0][7:0] held, held_next;
  logic [7:0]                 store [STORE_DEPTH];
  logic                       store_we;
  logic                       frame_ok;
  logic [1:0]                 event_code;

  always_comb begin
    pos_next   = pos;
    sum_next   = sum;
    stale_next = stale;
    held_next  = held;
    event_code = EV_NONE;
    store_we   = 1'b0;
    frame_ok   = 1'b0;
    if (!command) begin
      if (pos < POS_W'(STORE_DEPTH)) begin
        store_we = 1'b1;
        sum_next = sum + rx_byte;
        pos_next = pos + 1'b1;
      end else begin
        frame_ok = (store[0] == cfg.start_marker) &&
                   (!cfg.checksum_enable || (sum == rx_byte));
        if (frame_ok) begin
          for (int i = 0; i < HELD_COUNT; i++) begin
            held_next[i] = store[i+1];
          end
          stale_next = '0;
          event_code = EV_ACCEPT;
        end else begin
          event_code = EV_REJECT;
        end
        pos_next = '0;
        sum_next = '0;
      end
    end else begin
      if (stale != STALE_MAX) begin
        stale_next = stale + 1'b1;
      end
      if (stale_next > {1'b0, cfg.timeout_ticks}) begin
        pos_next = '0;
        sum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      sum   <= '0;
      stale <= '0;
      held  <= '0;
    end else if (step) begin
      pos   <= pos_next;
      sum   <= sum_next;
      stale <= stale_next;
      held  <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (step && store_we && (pos == POS_W'(i))) begin
        store[i] <= rx_byte;
      end
    end
  end

  assign res.held         = held_next;
  assign res.frame_event  = event_code;
  assign res.link_timeout = stale_next > {1'b0, cfg.timeout_ticks};
  assign position         = pos;

endmodule

`default_nettype wire

// ===== rtl/joystick_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// joystick_packet_receiver
// Fixed 10-byte frame deframer with additive checksum and link watchdog.
// An input register, then a result register, lie between input transaction and result;
//   one item per cycle sustained while m_tready does not stall the result stream.
// Throughput is set by the state update in the core.
// Reset clears control state and held fields and loads register defaults;
//   the frame byte store has no reset and is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_packet_receiver
  import jpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte
  input  wire logic [0:0]  s_tuser,   // command
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // button_low, button_high, left_trigger,
                                      // right_trigger, left_stick_x, left_stick_y,
                                      // right_stick_x, right_stick_y
  output logic [2:0]       m_tuser    // frame_event[1:0], link_timeout
);

  cfg_t             cfg;
  logic             cfg_wr;
  logic             in_valid;
  logic             in_cmd;
  logic [7:0]       in_byte;
  logic             out_ready;
  logic             step;
  result_t          res;
  logic [POS_W-1:0] position;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker    <= '0;
      cfg.checksum_enable <= 1'b1;
      cfg.timeout_ticks   <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START_MARKER:    cfg.start_marker    <= pwdata[7:0];
        REG_CHECKSUM_ENABLE: cfg.checksum_enable <= pwdata[0];
        REG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_MARKER:    prdata = {24'd0, cfg.start_marker};
      REG_CHECKSUM_ENABLE: prdata = {31'd0, cfg.checksum_enable};
      REG_TIMEOUT_TICKS:   prdata = {16'd0, cfg.timeout_ticks};
      default:             prdata = '0;
    endcase
  end

  assign out_ready = !m_tvalid || m_tready;
  assign step      = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser[0];
      in_byte <= s_tdata;
    end
  end

  jpr_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .command  (in_cmd),
    .rx_byte  (in_byte),
    .cfg      (cfg),
    .res      (res),
    .position (position)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= res.held;
      m_tuser <= {res.link_timeout, res.frame_event};
    end
  end

  // an accepted frame clears the watchdog, so it never reports a timeout
  a_accept_no_timeout: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && (m_tuser[1:0] == EV_ACCEPT) && m_tuser[2]))
    else $error("accepted frame reported with link timeout");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(STORE_DEPTH))
    else $error("frame position out of range");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1:0] != 2'd3))
    else $error("undefined frame event code");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
